>>> sv/lcb_pkg.sv
package lcb_pkg;

   localparam int REALS_DEF = 16;
   localparam int BUCKETS_DEF = 1024;
   localparam int WAYS_DEF = 4;

   localparam int KIND_W = 3;
   localparam int SLOT_W = 4;
   localparam int IP_W = 32;
   localparam int GRP_W = 16;
   localparam int CONN_W = 16;
   localparam int AGE_W = 16;
   localparam int RCNT_W = 5;
   localparam int TICK_W = 32;
   localparam int STAT_W = 2;
   localparam int CSR_IDX_W = 2;

   localparam logic [KIND_W-1:0] KIND_LOAD = 3'd0;
   localparam logic [KIND_W-1:0] KIND_BAL = 3'd1;
   localparam logic [KIND_W-1:0] KIND_OPEN = 3'd2;
   localparam logic [KIND_W-1:0] KIND_CLOSE = 3'd3;
   localparam logic [KIND_W-1:0] KIND_TICK = 3'd4;

   localparam logic [STAT_W-1:0] ST_OK = 2'd0;
   localparam logic [STAT_W-1:0] ST_HIT = 2'd1;
   localparam logic [STAT_W-1:0] ST_NOSRV = 2'd2;
   localparam logic [STAT_W-1:0] ST_FULL = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_STICKY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AGE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RCNT = 2'd2;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_FIND, S_CONN, S_AFF, S_LEAST, S_INS, S_DFIND, S_DONE
   } state_type;

   typedef struct packed {
      logic sticky;
      logic [AGE_W-1:0] age;
      logic [RCNT_W-1:0] rcnt;
   } cfg_type;

endpackage

>>> sv/least_conn_balancer_with_affinity_top.sv
// One item in, one result out per item. The result is on the rsp_ ports for a single cycle,
// marked by rsp_valid, and cannot be held off: the receiver must take it in that cycle.
// After reset the block first clears the affinity memory, one entry a cycle; busy stays
// high meanwhile. Load, tick and unused kinds go straight to their result. Open and close
// sweep the server-table memory port to find the named server. A balance sweeps it once
// to find the named server and once more, either for the least-connection scan or to
// resolve an affinity destination; when sticky is set, the affinity ways are read in
// between, one way at a time: each read is issued, then inspected.
module least_conn_balancer_with_affinity_top #(
   parameter int REALS = lcb_pkg::REALS_DEF,
   parameter int BUCKETS = lcb_pkg::BUCKETS_DEF,
   parameter int WAYS = lcb_pkg::WAYS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic [lcb_pkg::KIND_W-1:0] req_kind,
   input  logic [lcb_pkg::SLOT_W-1:0] req_entry_index,
   input  logic [lcb_pkg::IP_W-1:0] req_server_ip,
   input  logic [lcb_pkg::GRP_W-1:0] req_group_id,
   input  logic [lcb_pkg::IP_W-1:0] req_src_ip,
   output logic rsp_valid,
   output logic [lcb_pkg::STAT_W-1:0] rsp_status,
   output logic [lcb_pkg::IP_W-1:0] rsp_chosen_ip,
   output logic [lcb_pkg::SLOT_W-1:0] rsp_chosen_index,
   output logic rsp_affinity_expired,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [lcb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0] csr_data
);
   import lcb_pkg::*;

   localparam int RW = (REALS > 1) ? $clog2(REALS) : 1;
   localparam int CW = $clog2(REALS + 1);
   localparam int SLOTS = BUCKETS * WAYS;
   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int WW = $clog2(WAYS + 1);
   localparam int SDW = IP_W + GRP_W + CONN_W;
   localparam int ADW = 1 + 2*IP_W + GRP_W + TICK_W;

   state_type state_ff, state_in;
   cfg_type cfg_ff, cfg_in;
   logic [TICK_W-1:0] now_ff, now_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [IP_W-1:0] ip_ff, ip_in;
   logic [GRP_W-1:0] grp_ff, grp_in;
   logic [IP_W-1:0] src_ff, src_in;
   logic [CW-1:0] cnt_ff, cnt_in;      // address issued
   logic rvld_ff, rvld_in;              // read data valid for address cnt_ff-1
   logic [RW-1:0] ridx_ff, ridx_in;
   logic [RW-1:0] hit_ff, hit_in;
   logic [GRP_W-1:0] vid_ff, vid_in;
   logic [CONN_W-1:0] best_ff, best_in;
   logic [RW-1:0] pick_ff, pick_in;
   logic [IP_W-1:0] pip_ff, pip_in;
   logic [WW-1:0] way_ff, way_in;
   logic [WW-1:0] free_ff, free_in;
   logic fvld_ff, fvld_in;
   logic exp_ff, exp_in;
   logic [IP_W-1:0] dest_ff, dest_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic ovld_ff, ovld_in;
   logic [STAT_W-1:0] ost_ff, ost_in;
   logic [IP_W-1:0] oip_ff, oip_in;
   logic [SLOT_W-1:0] oidx_ff, oidx_in;
   logic oexp_ff, oexp_in;

   logic s_we;
   logic [RW-1:0] s_wa, s_ra;
   logic [SDW-1:0] s_wd, s_rd;
   logic a_we;
   logic [AW-1:0] a_wa, a_ra;
   logic [ADW-1:0] a_wd, a_rd;

   logic [IP_W-1:0] rd_ip;
   logic [GRP_W-1:0] rd_grp;
   logic [CONN_W-1:0] rd_conn;
   logic av;
   logic [IP_W-1:0] a_src, a_dst;
   logic [GRP_W-1:0] a_grp;
   logic [TICK_W-1:0] a_exp;
   logic [CW-1:0] n_live;
   logic [AW-1:0] base;
   logic in_slot_ok;

   assign {rd_ip, rd_grp, rd_conn} = s_rd;
   assign {av, a_src, a_dst, a_grp, a_exp} = a_rd;
   assign n_live = (32'(cfg_ff.rcnt) > REALS) ? CW'(REALS) : CW'(cfg_ff.rcnt);
   assign base = AW'((src_ff % BUCKETS) * WAYS);
   assign in_slot_ok = (32'(slot_ff) < REALS);

   lcb_srv_mem #(.REALS(REALS), .RW(RW)) u_srv (
      .clock(clock), .we(s_we), .waddr(s_wa), .wdata(s_wd),
      .raddr(s_ra), .rdata(s_rd)
   );

   lcb_aff_mem #(.DEPTH(SLOTS), .AW(AW), .DW(ADW)) u_aff (
      .clock(clock), .we(a_we), .waddr(a_wa), .wdata(a_wd),
      .raddr(a_ra), .rdata(a_rd)
   );

   assign busy = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = ovld_ff;
   assign rsp_status = ost_ff;
   assign rsp_chosen_ip = oip_ff;
   assign rsp_chosen_index = oidx_ff;
   assign rsp_affinity_expired = oexp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cfg_ff <= '0;
         now_ff <= '0;
         clr_ff <= '0;
         ovld_ff <= 1'b0;
         cnt_ff <= '0;
         rvld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cfg_ff <= cfg_in;
         now_ff <= now_in;
         clr_ff <= clr_in;
         ovld_ff <= ovld_in;
         cnt_ff <= cnt_in;
         rvld_ff <= rvld_in;
      end
      kind_ff <= kind_in; slot_ff <= slot_in; ip_ff <= ip_in; grp_ff <= grp_in;
      src_ff <= src_in; ridx_ff <= ridx_in; hit_ff <= hit_in; vid_ff <= vid_in;
      best_ff <= best_in; pick_ff <= pick_in; pip_ff <= pip_in; way_ff <= way_in;
      free_ff <= free_in; fvld_ff <= fvld_in; exp_ff <= exp_in; dest_ff <= dest_in;
      ost_ff <= ost_in; oip_ff <= oip_in; oidx_ff <= oidx_in; oexp_ff <= oexp_in;
   end

   always_comb begin
      state_in = state_ff;
      cfg_in = cfg_ff;
      now_in = now_ff;
      kind_in = kind_ff; slot_in = slot_ff; ip_in = ip_ff; grp_in = grp_ff;
      src_in = src_ff; cnt_in = cnt_ff; rvld_in = 1'b0; ridx_in = ridx_ff;
      hit_in = hit_ff; vid_in = vid_ff; best_in = best_ff; pick_in = pick_ff;
      pip_in = pip_ff; way_in = way_ff; free_in = free_ff; fvld_in = fvld_ff;
      exp_in = exp_ff; dest_in = dest_ff; clr_in = clr_ff;
      ovld_in = 1'b0; ost_in = ost_ff; oip_in = oip_ff; oidx_in = oidx_ff;
      oexp_in = oexp_ff;
      s_we = 1'b0; s_wa = ridx_ff; s_wd = {rd_ip, rd_grp, rd_conn};
      s_ra = RW'(cnt_ff);
      a_we = 1'b0; a_wa = clr_ff; a_wd = '0;
      a_ra = AW'(base + AW'(way_ff));

      if (csr_valid) begin
         case (csr_index)
            CSR_STICKY: cfg_in.sticky = csr_data[0];
            CSR_AGE: cfg_in.age = csr_data[AGE_W-1:0];
            CSR_RCNT: cfg_in.rcnt = csr_data[RCNT_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_CLEAR: begin
            a_we = 1'b1;
            a_wa = clr_ff;
            clr_in = clr_ff + AW'(1);
            if (32'(clr_ff) == SLOTS - 1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               kind_in = req_kind; slot_in = req_entry_index; ip_in = req_server_ip;
               grp_in = req_group_id; src_in = req_src_ip;
               cnt_in = '0; exp_in = 1'b0; way_in = '0; fvld_in = 1'b0;
               state_in = S_FIND;
               if (req_kind == KIND_LOAD || req_kind == KIND_TICK || req_kind > KIND_TICK) begin
                  state_in = S_DONE;
               end
            end
         end
         S_FIND: begin
            // sweep for the first slot holding ip_ff
            if (rvld_ff && rd_ip == ip_ff) begin
               hit_in = ridx_ff;
               vid_in = rd_grp;
               best_in = rd_conn;
               pick_in = ridx_ff;
               pip_in = rd_ip;
               cnt_in = '0;
               way_in = '0;
               if (kind_ff == KIND_BAL) begin
                  state_in = cfg_ff.sticky ? S_AFF : S_LEAST;
               end else begin
                  s_we = 1'b1;
                  s_wa = ridx_ff;
                  if (kind_ff == KIND_OPEN) begin
                     s_wd = {rd_ip, rd_grp, (rd_conn == '1) ? rd_conn : rd_conn + 1'b1};
                  end else begin
                     s_wd = {rd_ip, rd_grp, (rd_conn == '0) ? rd_conn : rd_conn - 1'b1};
                  end
                  ovld_in = 1'b1; ost_in = ST_OK; oip_in = ip_ff;
                  oidx_in = SLOT_W'(ridx_ff); oexp_in = 1'b0;
                  state_in = S_IDLE;
               end
            end else if (cnt_ff >= n_live && !(rvld_ff && cnt_ff != n_live)) begin
               if (!rvld_ff || cnt_ff == n_live) begin
                  if (!rvld_ff) begin
                     ovld_in = 1'b1; ost_in = ST_NOSRV; oip_in = ip_ff;
                     oidx_in = '0; oexp_in = 1'b0;
                     state_in = S_IDLE;
                  end
               end
            end
            if (state_in == S_FIND) begin
               if (cnt_ff < n_live) begin
                  s_ra = RW'(cnt_ff);
                  ridx_in = RW'(cnt_ff);
                  cnt_in = cnt_ff + CW'(1);
                  rvld_in = 1'b1;
               end
            end
         end
         S_AFF: begin
            // each way in turn: issue read, then inspect
            a_ra = AW'(base + AW'(way_ff));
            if (!rvld_ff) begin
               rvld_in = 1'b1;
            end else begin
               if (!av && !fvld_ff) begin
                  fvld_in = 1'b1;
                  free_in = way_ff;
               end
               if (av && a_src == src_ff && a_grp == vid_ff) begin
                  if (a_exp > now_ff) begin
                     dest_in = a_dst;
                     pick_in = hit_ff;
                     cnt_in = '0;
                     state_in = S_DFIND;
                  end else begin
                     a_we = 1'b1;
                     a_wa = AW'(base + AW'(way_ff));
                     a_wd = '0;
                     exp_in = 1'b1;
                     if (!fvld_ff) begin
                        fvld_in = 1'b1;
                        free_in = way_ff;
                     end
                     cnt_in = '0;
                     state_in = S_LEAST;
                  end
               end else if (32'(way_ff) == WAYS - 1) begin
                  cnt_in = '0;
                  state_in = S_LEAST;
               end else begin
                  way_in = way_ff + WW'(1);
               end
            end
         end
         S_LEAST: begin
            if (rvld_ff && rd_grp == vid_ff && rd_conn < best_ff) begin
               best_in = rd_conn;
               pick_in = ridx_ff;
               pip_in = rd_ip;
            end
            if (cnt_ff < n_live) begin
               s_ra = RW'(cnt_ff);
               ridx_in = RW'(cnt_ff);
               cnt_in = cnt_ff + CW'(1);
               rvld_in = 1'b1;
            end else if (!rvld_ff) begin
               state_in = S_INS;
            end
         end
         S_INS: begin
            ovld_in = 1'b1;
            oip_in = pip_ff;
            oidx_in = SLOT_W'(pick_ff);
            oexp_in = exp_ff;
            ost_in = ST_OK;
            if (cfg_ff.sticky) begin
               if (fvld_ff) begin
                  a_we = 1'b1;
                  a_wa = AW'(base + AW'(free_ff));
                  a_wd = {1'b1, src_ff, pip_ff, vid_ff, now_ff + TICK_W'(cfg_ff.age)};
               end else begin
                  ost_in = ST_FULL;
               end
            end
            state_in = S_IDLE;
         end
         S_DFIND: begin
            if (rvld_ff && rd_ip == dest_ff) begin
               ovld_in = 1'b1; ost_in = ST_HIT; oip_in = dest_ff;
               oidx_in = SLOT_W'(ridx_ff); oexp_in = 1'b0;
               state_in = S_IDLE;
            end else if (cnt_ff < n_live) begin
               s_ra = RW'(cnt_ff);
               ridx_in = RW'(cnt_ff);
               cnt_in = cnt_ff + CW'(1);
               rvld_in = 1'b1;
            end else if (!rvld_ff) begin
               ovld_in = 1'b1; ost_in = ST_HIT; oip_in = dest_ff;
               oidx_in = SLOT_W'(hit_ff); oexp_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         S_DONE: begin
            ovld_in = 1'b1; ost_in = ST_OK; oip_in = ip_ff; oexp_in = 1'b0;
            oidx_in = '0;
            if (kind_ff == KIND_LOAD) begin
               oidx_in = slot_ff;
               if (in_slot_ok) begin
                  s_we = 1'b1;
                  s_wa = RW'(slot_ff);
                  s_wd = {ip_ff, grp_ff, CONN_W'(0)};
               end
            end else if (kind_ff == KIND_TICK) begin
               now_in = now_ff + TICK_W'(1);
            end
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

>>> sv/lcb_srv_mem.sv
module lcb_srv_mem #(
   parameter int REALS = lcb_pkg::REALS_DEF,
   parameter int RW = (REALS > 1) ? $clog2(REALS) : 1
) (
   input  logic clock,
   input  logic we,
   input  logic [RW-1:0] waddr,
   input  logic [lcb_pkg::IP_W+lcb_pkg::GRP_W+lcb_pkg::CONN_W-1:0] wdata,
   input  logic [RW-1:0] raddr,
   output logic [lcb_pkg::IP_W+lcb_pkg::GRP_W+lcb_pkg::CONN_W-1:0] rdata
);
   import lcb_pkg::*;
   logic [IP_W+GRP_W+CONN_W-1:0] mem [REALS];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

>>> sv/lcb_aff_mem.sv
module lcb_aff_mem #(
   parameter int DEPTH = lcb_pkg::BUCKETS_DEF * lcb_pkg::WAYS_DEF,
   parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   parameter int DW = 1 + 2*lcb_pkg::IP_W + lcb_pkg::GRP_W + lcb_pkg::TICK_W
) (
   input  logic clock,
   input  logic we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic [AW-1:0] raddr,
   output logic [DW-1:0] rdata
);
   logic [DW-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

>>> sv/lcb_check.sv
module lcb_check (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic [lcb_pkg::STAT_W-1:0] rsp_status,
   input logic rsp_affinity_expired,
   input logic [lcb_pkg::SLOT_W-1:0] rsp_chosen_index
);
   import lcb_pkg::*;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("item accepted without busy");
   a_rsp_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while busy");
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result repeated");
   a_exp_stat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_affinity_expired |-> (rsp_status == ST_OK || rsp_status == ST_FULL))
      else $error("expiry with wrong status");
   a_nosrv_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_NOSRV |-> rsp_chosen_index == '0)
      else $error("not found with index");
endmodule

bind least_conn_balancer_with_affinity_top lcb_check u_lcb_check (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .rsp_valid(rsp_valid),
   .rsp_status(rsp_status), .rsp_affinity_expired(rsp_affinity_expired),
   .rsp_chosen_index(rsp_chosen_index)
);

>>> bench/tb_top.sv
module tb_top;
   import lcb_pkg::*;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [IP_W-1:0] chosen_ip;
      logic [SLOT_W-1:0] chosen_index;
      logic expired;
   } balance_rsp_type;

   localparam int N_SRV = REALS_DEF;
   localparam int N_AFF = BUCKETS_DEF * WAYS_DEF;
   localparam logic [2:0] KIND_SPARE = 3'd5;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [KIND_W-1:0] req_kind = '0;
   logic [SLOT_W-1:0] req_entry_index = '0;
   logic [IP_W-1:0] req_server_ip = '0;
   logic [GRP_W-1:0] req_group_id = '0;
   logic [IP_W-1:0] req_src_ip = '0;
   logic rsp_valid;
   logic [STAT_W-1:0] rsp_status;
   logic [IP_W-1:0] rsp_chosen_ip;
   logic [SLOT_W-1:0] rsp_chosen_index;
   logic rsp_affinity_expired;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   least_conn_balancer_with_affinity_top uut (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // predicted block state
   logic [IP_W-1:0] srv_addr[N_SRV];
   logic [GRP_W-1:0] srv_group[N_SRV];
   logic [CONN_W-1:0] srv_conns[N_SRV];
   bit aff_live[N_AFF];
   logic [IP_W-1:0] aff_src[N_AFF];
   logic [IP_W-1:0] aff_dst[N_AFF];
   logic [GRP_W-1:0] aff_grp[N_AFF];
   logic [TICK_W-1:0] aff_until[N_AFF];
   logic [TICK_W-1:0] tick_now = 0;
   logic sticky_on = 0;
   logic [AGE_W-1:0] sticky_ticks = 0;
   logic [RCNT_W-1:0] server_cnt = 0;

   balance_rsp_type pending_rsp[$];
   int idle_pct = 0;
   int mismatches = 0;
   bit failed = 0;

   function automatic int active_servers();
      return (server_cnt > N_SRV) ? N_SRV : int'(server_cnt);
   endfunction

   function automatic int lookup_server(input logic [IP_W-1:0] addr);
      for (int i = 0; i < active_servers(); i++)
         if (srv_addr[i] == addr) return i;
      return -1;
   endfunction

   function automatic int least_loaded(input int from);
      int pick = from;
      logic [CONN_W-1:0] best = srv_conns[from];
      for (int j = 0; j < active_servers(); j++)
         if (srv_group[j] == srv_group[from] && srv_conns[j] < best) begin
            best = srv_conns[j];
            pick = j;
         end
      return pick;
   endfunction

   function automatic balance_rsp_type predict_balance(input logic [KIND_W-1:0] k,
         input logic [SLOT_W-1:0] slot, input logic [IP_W-1:0] ip,
         input logic [GRP_W-1:0] grp, input logic [IP_W-1:0] src);
      balance_rsp_type r;
      int hit, pick, base, freeway, d;
      r = '{status: ST_OK, chosen_ip: ip, chosen_index: '0, expired: 1'b0};
      if (k == KIND_LOAD) begin
         srv_addr[slot] = ip;
         srv_group[slot] = grp;
         srv_conns[slot] = '0;
         r.chosen_index = slot;
         return r;
      end
      if (k == KIND_TICK) begin
         tick_now++;
         return r;
      end
      if (k > KIND_TICK) return r;
      hit = lookup_server(ip);
      if (hit < 0) begin
         r.status = ST_NOSRV;
         return r;
      end
      if (k == KIND_OPEN || k == KIND_CLOSE) begin
         if (k == KIND_OPEN && srv_conns[hit] != '1) srv_conns[hit]++;
         if (k == KIND_CLOSE && srv_conns[hit] != '0) srv_conns[hit]--;
         r.chosen_index = hit[SLOT_W-1:0];
         return r;
      end
      if (sticky_on) begin
         base = (src % BUCKETS_DEF) * WAYS_DEF;
         freeway = -1;
         for (int w = 0; w < WAYS_DEF; w++) begin
            if (aff_live[base+w] && aff_src[base+w] == src &&
                  aff_grp[base+w] == srv_group[hit]) begin
               if (aff_until[base+w] > tick_now) begin
                  d = lookup_server(aff_dst[base+w]);
                  r.status = ST_HIT;
                  r.chosen_ip = aff_dst[base+w];
                  r.chosen_index = (d < 0) ? hit[SLOT_W-1:0] : d[SLOT_W-1:0];
                  return r;
               end
               aff_live[base+w] = 0;
               r.expired = 1;
               break;
            end
         end
         pick = least_loaded(hit);
         for (int w = 0; w < WAYS_DEF; w++)
            if (!aff_live[base+w]) begin
               freeway = base + w;
               break;
            end
         if (freeway >= 0) begin
            aff_live[freeway] = 1;
            aff_src[freeway] = src;
            aff_dst[freeway] = srv_addr[pick];
            aff_grp[freeway] = srv_group[hit];
            aff_until[freeway] = tick_now + TICK_W'(sticky_ticks);
         end else begin
            r.status = ST_FULL;
         end
      end else begin
         pick = least_loaded(hit);
      end
      r.chosen_ip = srv_addr[pick];
      r.chosen_index = pick[SLOT_W-1:0];
      return r;
   endfunction

   task automatic send_item(input logic [KIND_W-1:0] k, input logic [SLOT_W-1:0] slot,
         input logic [IP_W-1:0] ip, input logic [GRP_W-1:0] grp, input logic [IP_W-1:0] src);
      req_kind <= k;
      req_entry_index <= slot;
      req_server_ip <= ip;
      req_group_id <= grp;
      req_src_ip <= src;
      if (!start) start <= 1;
      do @(posedge clock); while (busy);
      pending_rsp.push_back(predict_balance(k, slot, ip, grp, src));
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic drain();
      if (start) start <= 0;
      @(posedge clock);
      while (pending_rsp.size() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      case (idx)
         CSR_STICKY: sticky_on = value[0];
         CSR_AGE: sticky_ticks = value[AGE_W-1:0];
         CSR_RCNT: server_cnt = value[RCNT_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      balance_rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            failed = 1;
            mismatches++;
            if (mismatches <= 10) $display("unexpected item: status %0d ip %h", rsp_status,
               rsp_chosen_ip);
         end else begin
            want = pending_rsp.pop_front();
            if (want.status !== rsp_status || want.chosen_ip !== rsp_chosen_ip ||
                  want.chosen_index !== rsp_chosen_index ||
                  want.expired !== rsp_affinity_expired) begin
               failed = 1;
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp st %0d ip %h idx %0d ex %0d, got st %0d ip %h idx %0d ex %0d",
                     want.status, want.chosen_ip, want.chosen_index, want.expired,
                     rsp_status, rsp_chosen_ip, rsp_chosen_index, rsp_affinity_expired);
            end
         end
      end
   end

   task automatic test_table_load();
      drain();
      csr_write(CSR_RCNT, '0);
      for (int i = 0; i < N_SRV - 1; i++)
         send_item(KIND_LOAD, SLOT_W'(i), 32'h0A00_0000 + i, GRP_W'(i % 3), '0);
      send_item(KIND_LOAD, 4'hF, '1, '1, '1);
      drain();
      csr_write(CSR_RCNT, 32'(N_SRV));
   endtask

   task automatic test_connections();
      repeat (3) send_item(KIND_OPEN, '0, 32'h0A00_0002, '0, '0);
      repeat (4) send_item(KIND_CLOSE, '0, 32'h0A00_0002, '0, '0);
      send_item(KIND_OPEN, '0, 32'h0A00_0003, '0, '0);
      send_item(KIND_OPEN, '0, '0, '0, '0);
      send_item(KIND_CLOSE, '0, 32'h1234_5678, '0, '0);
      send_item(KIND_TICK, '0, 32'h5555_AAAA, '0, '0);
      for (int k = KIND_SPARE; k < 8; k++)
         send_item(KIND_W'(k), 4'hA, 32'hAAAA_5555, '1, '1);
   endtask

   task automatic test_plain_balance();
      send_item(KIND_BAL, '0, 32'h0A00_0003, '0, 32'h1);
      send_item(KIND_BAL, '0, '1, '0, 32'h2);
      drain();
   endtask

   task automatic test_affinity();
      csr_write(CSR_STICKY, 32'd1);
      csr_write(CSR_AGE, 32'd2);
      send_item(KIND_BAL, '0, 32'h0A00_0004, '0, 32'd5);
      send_item(KIND_BAL, '0, 32'h0A00_0004, '0, 32'd5);
      repeat (2) send_item(KIND_TICK, '0, '0, '0, '0);
      send_item(KIND_BAL, '0, 32'h0A00_0004, '0, 32'd5);
      for (int i = 1; i <= 4; i++)
         send_item(KIND_BAL, '0, 32'h0A00_0001, '0, 32'(5 + i * BUCKETS_DEF));
      send_item(KIND_BAL, '0, 32'hDEAD_BEEF, '0, 32'd5);
      drain();
   endtask

   function automatic logic [IP_W-1:0] known_addr();
      if (active_servers() == 0 || $urandom_range(0, 7) == 0) return $urandom;
      return srv_addr[$urandom_range(0, active_servers() - 1)];
   endfunction

   task automatic random_item();
      int r;
      logic [IP_W-1:0] src;
      r = $urandom_range(0, 99);
      src = 32'h0A00_0000 + ($urandom_range(0, 5) << 10) + $urandom_range(0, 3);
      if ($urandom_range(0, 9) == 0) src = $urandom;
      if (r < 40)
         send_item(KIND_BAL, SLOT_W'($urandom), known_addr(), GRP_W'($urandom), src);
      else if (r < 60)
         send_item(KIND_OPEN, SLOT_W'($urandom), known_addr(), GRP_W'($urandom), $urandom);
      else if (r < 75)
         send_item(KIND_CLOSE, SLOT_W'($urandom), known_addr(), GRP_W'($urandom), $urandom);
      else if (r < 85)
         send_item(KIND_TICK, SLOT_W'($urandom), $urandom, GRP_W'($urandom), $urandom);
      else if (r < 92)
         send_item(KIND_LOAD, SLOT_W'($urandom), ($urandom_range(0, 3) == 0) ? $urandom :
            32'h0A00_0000 + $urandom_range(0, 19), GRP_W'($urandom_range(0, 3)), $urandom);
      else if (r < 95)
         send_item(KIND_W'($urandom_range(KIND_SPARE, 7)), SLOT_W'($urandom), $urandom,
            GRP_W'($urandom), $urandom);
      else
         send_item(KIND_W'($urandom_range(0, 7)), SLOT_W'($urandom), $urandom,
            GRP_W'($urandom), $urandom);
   endtask

   task automatic test_random_traffic();
      int ages[5] = '{0, 1, 3, 20, 65535};
      int counts[5] = '{16, 31, 7, 1, 0};
      int pct[3] = '{16, 61, 0};
      for (int p = 0; p < 3; p++) begin
         idle_pct = pct[p];
         for (int c = 0; c < 4; c++) begin
            drain();
            csr_write(CSR_STICKY, 32'($urandom_range(0, 3) != 0));
            csr_write(CSR_AGE, ages[$urandom_range(0, 4)]);
            csr_write(CSR_RCNT, (c == 0) ? 16 : counts[$urandom_range(0, 4)]);
            repeat (54) random_item();
            drain();
            repeat (54) random_item();
         end
      end
      drain();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 0;
      test_table_load();
      test_connections();
      test_plain_balance();
      test_affinity();
      test_random_traffic();
      repeat (80) @(posedge clock);
      if (!failed && pending_rsp.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("Verification failed");
      $finish;
   end

endmodule
